/* hdl/sptb_pkg.sv */
package sptb_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BGR_ORDER  = 3'd4;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // channel slots in the per-channel arrays
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;
    localparam int NUM_CH   = 3;

    typedef struct packed {
        logic [7:0] cov_first;
        logic [7:0] cov_second;
        logic [7:0] cov_third;
        logic [7:0] dst_blue;
        logic [7:0] dst_green;
        logic [7:0] dst_red;
        logic [7:0] dst_alpha;
    } t_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } t_out;

    typedef struct packed {
        logic [7:0] text_red;
        logic [7:0] text_green;
        logic [7:0] text_blue;
        logic [7:0] pass_alpha;
        logic       bgr_order;
    } t_cfg;

    // scaled pixel handed from the scale unit to the blend unit
    typedef struct packed {
        logic [NUM_CH-1:0][7:0] cov;
        logic [NUM_CH-1:0][7:0] color;
        logic [NUM_CH-1:0][7:0] dst;
        logic [7:0]             alpha;
    } t_mid;

    // exact x / 255 for any product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

/* hdl/lcd_subpixel_text_blend.sv */
// a pixel accepted with i_valid and o_ready moves through the register stages below in order to o_valid
// throughput: one pixel per cycle while i_ready is high, four register stages (multiply, /255, multiply, /255)
// each stage holds its pixel while the next is full, so o_ready falls only when all are full
// reset (synchronous, active low) empties the pipeline and loads the register defaults:
// text color black, pass alpha 255, rgb subpixel order
module lcd_subpixel_text_blend
    import sptb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out                 o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg r_cfg;
    logic mid_valid;
    logic mid_ready;
    t_mid mid_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_red   <= 8'd0;
            r_cfg.text_green <= 8'd0;
            r_cfg.text_blue  <= 8'd0;
            r_cfg.pass_alpha <= FULL_SCALE;
            r_cfg.bgr_order  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEXT_RED:   r_cfg.text_red   <= i_cfg_data;
                CFG_TEXT_GREEN: r_cfg.text_green <= i_cfg_data;
                CFG_TEXT_BLUE:  r_cfg.text_blue  <= i_cfg_data;
                CFG_PASS_ALPHA: r_cfg.pass_alpha <= i_cfg_data;
                CFG_BGR_ORDER:  r_cfg.bgr_order  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sptb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_data  (mid_data)
    );

    sptb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_data  (mid_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

/* hdl/sptb_scale.sv */
module sptb_scale
    import sptb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_mid o_data
);

    logic                    r_va;
    logic [NUM_CH-1:0][15:0] r_cov_prod;
    logic [NUM_CH-1:0][15:0] r_col_prod;
    logic [NUM_CH-1:0][7:0]  r_dst;
    logic [7:0]              r_dst_alpha;
    logic                    r_vb;
    t_mid                    r_mid;
    t_mid                    n_mid;

    logic                    ready_a;
    logic                    ready_b;
    logic [NUM_CH-1:0][7:0]  cov_sel;
    logic [NUM_CH-1:0][7:0]  col_sel;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;

    // scaling by full scale is exact, so the product path also covers solid text
    always_comb begin
        cov_sel[CH_GREEN] = i_data.cov_second;
        if (i_cfg.bgr_order) begin
            cov_sel[CH_RED]  = i_data.cov_third;
            cov_sel[CH_BLUE] = i_data.cov_first;
        end else begin
            cov_sel[CH_RED]  = i_data.cov_first;
            cov_sel[CH_BLUE] = i_data.cov_third;
        end
        col_sel[CH_RED]   = i_cfg.text_red;
        col_sel[CH_GREEN] = i_cfg.text_green;
        col_sel[CH_BLUE]  = i_cfg.text_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (ready_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_cov_prod[c] <= 16'(cov_sel[c]) * 16'(i_cfg.pass_alpha);
                r_col_prod[c] <= 16'(col_sel[c]) * 16'(i_cfg.pass_alpha);
            end
            r_dst[CH_BLUE]  <= i_data.dst_blue;
            r_dst[CH_GREEN] <= i_data.dst_green;
            r_dst[CH_RED]   <= i_data.dst_red;
            r_dst_alpha     <= i_data.dst_alpha;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_mid.cov[c]   = div255(r_cov_prod[c]);
            n_mid.color[c] = div255(r_col_prod[c]);
        end
        n_mid.dst = r_dst;
        // any surviving coverage clears the alpha
        if ((n_mid.cov[CH_RED] | n_mid.cov[CH_GREEN] | n_mid.cov[CH_BLUE]) != 8'd0) begin
            n_mid.alpha = 8'd0;
        end else begin
            n_mid.alpha = r_dst_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (ready_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_va) begin
            r_mid <= n_mid;
        end
    end

    assign o_valid = r_vb;
    assign o_data  = r_mid;

endmodule

/* hdl/sptb_blend.sv */
module sptb_blend
    import sptb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_mid i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic                    r_vc;
    logic [NUM_CH-1:0][15:0] r_prod;
    logic [NUM_CH-1:0]       r_neg;
    logic [NUM_CH-1:0][7:0]  r_dst;
    logic [7:0]              r_alpha;
    logic                    r_vd;
    t_out                    r_out;
    t_out                    n_out;

    logic                    ready_c;
    logic                    ready_d;
    logic [NUM_CH-1:0][7:0]  diff_mag;
    logic [NUM_CH-1:0]       diff_neg;
    logic [NUM_CH-1:0][7:0]  step;
    logic [NUM_CH-1:0][7:0]  chan;

    assign ready_d = !r_vd || i_ready;
    assign ready_c = !r_vc || ready_d;
    assign o_ready = ready_c;

    // magnitude and sign of color - dst, so the quotient truncates toward zero
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            diff_neg[c] = i_data.color[c] < i_data.dst[c];
            if (diff_neg[c]) begin
                diff_mag[c] = i_data.dst[c] - i_data.color[c];
            end else begin
                diff_mag[c] = i_data.color[c] - i_data.dst[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (ready_c) begin
            r_vc <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && i_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= 16'(diff_mag[c]) * 16'(i_data.cov[c]);
            end
            r_neg   <= diff_neg;
            r_dst   <= i_data.dst;
            r_alpha <= i_data.alpha;
        end
    end

    // result stays between dst and color, no wrap possible
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            step[c] = div255(r_prod[c]);
            if (r_neg[c]) begin
                chan[c] = r_dst[c] - step[c];
            end else begin
                chan[c] = r_dst[c] + step[c];
            end
        end
        n_out.out_blue  = chan[CH_BLUE];
        n_out.out_green = chan[CH_GREEN];
        n_out.out_red   = chan[CH_RED];
        n_out.out_alpha = r_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (ready_d) begin
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_d && r_vc) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vd;
    assign o_data  = r_out;

endmodule
